/* sv/keystroke_four_function_calculator_unit_assert.svh */
// Assertion macros for the keystroke calculator checker.
// Depends on nothing; included by the checker file.
`ifndef KEYSTROKE_FOUR_FUNCTION_CALCULATOR_UNIT_ASSERT_SVH
`define KEYSTROKE_FOUR_FUNCTION_CALCULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFFC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kffc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KFFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kffc: next-cycle check failed");

`endif

/* sv/kffc_pkg.sv */
// Shared types, key codes and constants for the keystroke calculator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package kffc_pkg;

    localparam int DATA_W              = 64;
    localparam int FRAC_BITS_DEF       = 24;
    localparam int MAX_FRAC_DIGITS_DEF = 6;
    localparam int POW10_W             = 24;

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // ASCII key codes.
    localparam logic [7:0] KEY_ENTER = 8'd13;
    localparam logic [7:0] KEY_MUL   = 8'd42;
    localparam logic [7:0] KEY_ADD   = 8'd43;
    localparam logic [7:0] KEY_SUB   = 8'd45;
    localparam logic [7:0] KEY_POINT = 8'd46;
    localparam logic [7:0] KEY_DIV   = 8'd47;
    localparam logic [7:0] KEY_ZERO  = 8'd48;
    localparam logic [7:0] KEY_NINE  = 8'd57;

    // Pending operation codes.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } calc_op_t;

    // Command to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } mdu_cmd_t;

    // Status from the shared multiply/divide unit.
    typedef struct packed {
        logic done;
        logic over;
    } mdu_stat_t;

    // Powers of ten used as fraction digit divisors.
    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] idx);
        logic [POW10_W-1:0] val;
        case (idx)
            3'd0:    val = POW10_W'(1);
            3'd1:    val = POW10_W'(10);
            3'd2:    val = POW10_W'(100);
            3'd3:    val = POW10_W'(1000);
            3'd4:    val = POW10_W'(10000);
            3'd5:    val = POW10_W'(100000);
            3'd6:    val = POW10_W'(1000000);
            default: val = POW10_W'(10000000);
        endcase
        return val;
    endfunction

endpackage

/* sv/kffc_mdu.sv */
// Shared iterative unit: radix-2 shift-add multiplier and restoring divider.
// Depends on kffc_pkg; one 66-bit adder serves both operations.
`timescale 1ns / 1ps

module kffc_mdu #(
    parameter int FRAC_BITS = kffc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  kffc_pkg::mdu_cmd_t                   cmd,
    input  logic [kffc_pkg::DATA_W-1:0]          opnd_in,
    input  logic [kffc_pkg::DATA_W+FRAC_BITS-1:0] dvd_in,
    output kffc_pkg::mdu_stat_t                  stat,
    output logic [2*kffc_pkg::DATA_W-1:0]        prod,
    output logic [kffc_pkg::DATA_W-1:0]          quo
);
    import kffc_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int ADD_W = DATA_W + 2;

    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] opnd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              div_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              over_reg;

    logic [ADD_W-1:0]  add_a;
    logic [ADD_W-1:0]  add_b;
    logic [ADD_W-1:0]  sum;

    // Shared adder: partial product add, or trial subtract of the divisor.
    always_comb begin
        if (div_reg) begin
            add_a = {1'b0, hi_reg, num_reg[NUM_W-1]};
            add_b = ~{2'b00, opnd_reg};
        end else begin
            add_a = {2'b00, hi_reg};
            add_b = lo_reg[0] ? {2'b00, opnd_reg} : '0;
        end
        sum = add_a + add_b + {{(ADD_W-1){1'b0}}, div_reg};
    end

    // Iteration registers and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            div_reg  <= cmd.is_div;
            hi_reg   <= '0;
            lo_reg   <= cmd.is_div ? '0 : dvd_in[DATA_W-1:0];
            num_reg  <= dvd_in;
            opnd_reg <= opnd_in;
            over_reg <= 1'b0;
            cnt_reg  <= cmd.is_div ? CNT_W'(NUM_W) : CNT_W'(DATA_W);
        end else if (busy_reg) begin
            if (div_reg) begin
                // Quotient bit is one when the trial difference is not negative.
                if (!sum[ADD_W-1]) begin
                    hi_reg <= sum[DATA_W-1:0];
                end else begin
                    hi_reg <= add_a[DATA_W-1:0];
                end
                over_reg <= over_reg | lo_reg[DATA_W-1];
                lo_reg   <= {lo_reg[DATA_W-2:0], ~sum[ADD_W-1]};
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            end else begin
                hi_reg <= sum[DATA_W:1];
                lo_reg <= {sum[0], lo_reg[DATA_W-1:1]};
            end
            cnt_reg  <= cnt_reg - CNT_W'(1);
            // The last step ends the run and flags the result for one cycle.
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign prod      = {hi_reg, lo_reg};
    assign quo       = lo_reg;

endmodule

/* sv/keystroke_four_function_calculator_unit.sv */
// Digit, point, ignored keys, a first operator and enter with no operator go from S_KEY
// straight to S_RESULT; add, subtract and divide by zero pass through S_EVAL and S_APPLY;
// a multiply, a fraction digit and a divide wait in S_UNIT_WAIT or S_FRAC_WAIT for the
// shared unit, which takes one bit a cycle. One key word is in flight at a time; the next
// is taken the cycle after the word is loaded into the output register. Reset is
// synchronous, active low, and clears the sequencer, calculator state and output valid.
`timescale 1ns / 1ps

module keystroke_four_function_calculator_unit #(
    parameter int FRAC_BITS       = kffc_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = kffc_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_key_code,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [kffc_pkg::DATA_W-1:0]      m_display_value,
    output logic                                    m_is_total,
    output logic                                    m_error_flag
);
    import kffc_pkg::*;

    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int WIDE_W = DATA_W + 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_FRAC_WAIT,
        S_EVAL,
        S_UNIT_WAIT,
        S_FIX,
        S_APPLY,
        S_RESULT
    } state_t;

    state_t            state_reg;
    logic [7:0]        key_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] entry_reg;
    calc_op_t          pend_reg;
    logic              active_reg;
    logic              dec_reg;
    logic [2:0]        fpos_reg;
    logic              err_reg;
    logic [DATA_W-1:0] shown_reg;
    logic              total_reg;
    logic [DATA_W-1:0] mag_reg;
    logic              ovf_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] val_reg;
    logic              verr_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_disp_reg;
    logic              m_total_reg;
    logic              m_err_reg;

    // Key decode.
    logic              is_digit;
    logic [3:0]        digit;
    calc_op_t          key_op;
    logic [7:0]        digit_diff;

    always_comb begin
        is_digit   = (key_reg >= KEY_ZERO) && (key_reg <= KEY_NINE);
        digit_diff = key_reg - KEY_ZERO;
        digit      = digit_diff[3:0];
        unique case (key_reg)
            KEY_ADD: key_op = OP_ADD;
            KEY_SUB: key_op = OP_SUB;
            KEY_MUL: key_op = OP_MUL;
            KEY_DIV: key_op = OP_DIV;
            default: key_op = OP_NONE;
        endcase
    end

    // Integer digit: entry * 10 + digit, checked against the largest value.
    logic [DATA_W-1:0] dig_shift;
    logic [WIDE_W-1:0] times_ten;
    logic              int_ovf;
    logic [DATA_W-1:0] int_entry;

    always_comb begin
        dig_shift = {{(DATA_W-4){1'b0}}, digit} << FRAC_BITS;
        times_ten = ({4'b0000, entry_reg} << 3) + ({4'b0000, entry_reg} << 1)
                  + {4'b0000, dig_shift};
        int_ovf   = |times_ten[WIDE_W-1:DATA_W-1];
        int_entry = int_ovf ? POS_MAX : times_ten[DATA_W-1:0];
    end

    // Fraction digit: rounded (digit * 2^FRAC_BITS) / 10^position.
    logic [2:0]         pos_next;
    logic [POW10_W-1:0] pow_p;
    logic [NUM_W-1:0]   frac_dvd;
    logic               frac_ok;

    always_comb begin
        pos_next = fpos_reg + 3'd1;
        pow_p    = pow10(pos_next);
        frac_dvd = ({{(NUM_W-4){1'b0}}, digit} << FRAC_BITS)
                 + {{(NUM_W-POW10_W){1'b0}}, pow_p >> 1};
        frac_ok  = fpos_reg < 3'(MAX_FRAC_DIGITS);
    end

    // Add and subtract with saturation, combinational.
    logic              is_sub;
    logic [DATA_W-1:0] as_sum;
    logic              b_eff_neg;
    logic              as_ovf;
    logic [DATA_W-1:0] as_val;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;

    always_comb begin
        is_sub    = (pend_reg == OP_SUB);
        as_sum    = acc_reg + (is_sub ? ~entry_reg : entry_reg) + DATA_W'(is_sub);
        b_eff_neg = is_sub ? ((entry_reg == NEG_MIN) | (~entry_reg[DATA_W-1] & |entry_reg))
                           : entry_reg[DATA_W-1];
        as_ovf    = (acc_reg[DATA_W-1] == b_eff_neg)
                 && (as_sum[DATA_W-1] != acc_reg[DATA_W-1]);
        as_val    = as_ovf ? (acc_reg[DATA_W-1] ? NEG_MIN : POS_MAX) : as_sum;
        abs_a     = acc_reg[DATA_W-1] ? (~acc_reg + DATA_W'(1)) : acc_reg;
        abs_b     = entry_reg[DATA_W-1] ? (~entry_reg + DATA_W'(1)) : entry_reg;
    end

    // Operand selection for the shared unit.
    mdu_cmd_t            mdu_cmd;
    mdu_stat_t           mdu_stat;
    logic [DATA_W-1:0]   mdu_opnd;
    logic [NUM_W-1:0]    mdu_dvd;
    logic [2*DATA_W-1:0] mdu_prod;
    logic [DATA_W-1:0]   mdu_quo;

    always_comb begin
        mdu_cmd.start  = ((state_reg == S_KEY) && is_digit && dec_reg && frac_ok)
                      || ((state_reg == S_EVAL)
                          && ((pend_reg == OP_MUL)
                              || ((pend_reg == OP_DIV) && (entry_reg != '0))));
        mdu_cmd.is_div = !((state_reg == S_EVAL) && (pend_reg == OP_MUL));
        if (state_reg == S_KEY) begin
            mdu_opnd = {{(DATA_W-POW10_W){1'b0}}, pow_p};
            mdu_dvd  = frac_dvd;
        end else if (pend_reg == OP_MUL) begin
            mdu_opnd = abs_a;
            mdu_dvd  = {{FRAC_BITS{1'b0}}, abs_b};
        end else begin
            mdu_opnd = abs_b;
            mdu_dvd  = {abs_a, {FRAC_BITS{1'b0}}};
        end
    end

    kffc_mdu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mdu_cmd),
        .opnd_in (mdu_opnd),
        .dvd_in  (mdu_dvd),
        .stat    (mdu_stat),
        .prod    (mdu_prod),
        .quo     (mdu_quo)
    );

    // Fraction digit accumulate and saturation check.
    logic [DATA_W-1:0] frac_sum;
    logic              frac_ovf;
    logic              fix_sat;

    always_comb begin
        frac_sum = entry_reg + mdu_quo;
        frac_ovf = frac_sum[DATA_W-1];
        fix_sat  = ovf_reg
                || (mag_reg[DATA_W-1] && (!neg_reg || |mag_reg[DATA_W-2:0]));
    end

    // Sequencer, calculator state and output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            entry_reg   <= '0;
            pend_reg    <= OP_NONE;
            active_reg  <= 1'b0;
            dec_reg     <= 1'b0;
            fpos_reg    <= '0;
            err_reg     <= 1'b0;
            total_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A taken word frees the output unless a new one is loaded at once.
            if (m_valid_reg && m_ready && (state_reg != S_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        key_reg   <= s_key_code;
                        total_reg <= 1'b0;
                        state_reg <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (is_digit) begin
                        if (!dec_reg) begin
                            entry_reg <= int_entry;
                            shown_reg <= int_entry;
                            err_reg   <= err_reg | int_ovf;
                            state_reg <= S_RESULT;
                        end else if (frac_ok) begin
                            fpos_reg  <= pos_next;
                            state_reg <= S_FRAC_WAIT;
                        end else begin
                            shown_reg <= entry_reg;
                            state_reg <= S_RESULT;
                        end
                    end else if (key_reg == KEY_POINT) begin
                        dec_reg   <= 1'b1;
                        shown_reg <= entry_reg;
                        state_reg <= S_RESULT;
                    end else if ((key_op != OP_NONE) && active_reg) begin
                        state_reg <= S_EVAL;
                    end else if (key_op != OP_NONE) begin
                        acc_reg    <= entry_reg;
                        pend_reg   <= key_op;
                        active_reg <= 1'b1;
                        entry_reg  <= '0;
                        dec_reg    <= 1'b0;
                        fpos_reg   <= '0;
                        shown_reg  <= '0;
                        state_reg  <= S_RESULT;
                    end else if ((key_reg == KEY_ENTER) && active_reg) begin
                        state_reg <= S_EVAL;
                    end else begin
                        // Enter with no operator returns the entry as the total; other keys show the entry.
                        shown_reg <= entry_reg;
                        total_reg <= (key_reg == KEY_ENTER);
                        state_reg <= S_RESULT;
                    end
                end
                S_FRAC_WAIT: begin
                    if (mdu_stat.done) begin
                        entry_reg <= frac_ovf ? POS_MAX : frac_sum;
                        shown_reg <= frac_ovf ? POS_MAX : frac_sum;
                        err_reg   <= err_reg | frac_ovf;
                        state_reg <= S_RESULT;
                    end
                end
                S_EVAL: begin
                    neg_reg <= acc_reg[DATA_W-1] ^ entry_reg[DATA_W-1];
                    case (pend_reg) inside
                        OP_ADD, OP_SUB: begin
                            val_reg   <= as_val;
                            verr_reg  <= as_ovf;
                            state_reg <= S_APPLY;
                        end
                        OP_MUL: begin
                            state_reg <= S_UNIT_WAIT;
                        end
                        OP_DIV: begin
                            if (entry_reg == '0) begin
                                // Division by zero saturates by the dividend's sign.
                                val_reg   <= acc_reg[DATA_W-1] ? NEG_MIN : POS_MAX;
                                verr_reg  <= 1'b1;
                                state_reg <= S_APPLY;
                            end else begin
                                state_reg <= S_UNIT_WAIT;
                            end
                        end
                        default: begin
                            val_reg   <= entry_reg;
                            verr_reg  <= 1'b0;
                            state_reg <= S_APPLY;
                        end
                    endcase
                end
                S_UNIT_WAIT: begin
                    if (mdu_stat.done) begin
                        if (pend_reg == OP_MUL) begin
                            mag_reg <= mdu_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
                            ovf_reg <= |mdu_prod[2*DATA_W-1:DATA_W+FRAC_BITS];
                        end else begin
                            mag_reg <= mdu_quo;
                            ovf_reg <= mdu_stat.over;
                        end
                        state_reg <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Apply the sign to the magnitude, saturating out-of-range results.
                    if (fix_sat) begin
                        val_reg <= neg_reg ? NEG_MIN : POS_MAX;
                    end else begin
                        val_reg <= neg_reg ? (~mag_reg + DATA_W'(1)) : mag_reg;
                    end
                    verr_reg  <= fix_sat;
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    err_reg <= err_reg | verr_reg;
                    if (key_op != OP_NONE) begin
                        acc_reg    <= val_reg;
                        pend_reg   <= key_op;
                        active_reg <= 1'b1;
                        entry_reg  <= '0;
                        dec_reg    <= 1'b0;
                        fpos_reg   <= '0;
                        shown_reg  <= '0;
                    end else begin
                        shown_reg <= val_reg;
                        total_reg <= 1'b1;
                    end
                    state_reg <= S_RESULT;
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_disp_reg  <= shown_reg;
                        m_total_reg <= total_reg;
                        m_err_reg   <= err_reg;
                        // Enter clears the accumulator, entry, pending operation and error state.
                        if (total_reg) begin
                            acc_reg    <= '0;
                            entry_reg  <= '0;
                            pend_reg   <= OP_NONE;
                            active_reg <= 1'b0;
                            dec_reg    <= 1'b0;
                            fpos_reg   <= '0;
                            err_reg    <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_display_value = $signed(m_disp_reg);
    assign m_is_total      = m_total_reg;
    assign m_error_flag    = m_err_reg;

endmodule

/* sv/kffc_sva.sv */
// Port-level checker for the keystroke calculator, bound to the top level.
// Depends on kffc_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "keystroke_four_function_calculator_unit_assert.svh"

module kffc_sva (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [kffc_pkg::DATA_W-1:0] m_display_value,
    input logic                               m_is_total,
    input logic                               m_error_flag
);
    import kffc_pkg::*;

    // A stalled result word holds its value.
    `KFFC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_display_value) && $stable(m_is_total) && $stable(m_error_flag))

    // After a key word is taken the block is not ready in the next cycle.
    `KFFC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A new result word appears only as the sequencer returns to idle.
    `KFFC_ASSERT_SAME(a_result_at_idle, aclk, aresetn, $rose(m_valid), s_ready)

endmodule

bind keystroke_four_function_calculator_unit kffc_sva u_kffc_sva (.*);

/* verif/keystroke_four_function_calculator_unit_tb.sv */
// Self-checking testbench for keystroke_four_function_calculator_unit.
// Depends on kffc_pkg and the calculator RTL; drives key words in and checks
// every result word against a fixed-point predictor or, for typed rows, a table value.
`timescale 1ns / 1ps

module keystroke_four_function_calculator_unit_tb;
    import kffc_pkg::*;

    localparam int FRAC_BITS        = FRAC_BITS_DEF;
    localparam int MAX_FRAC_DIGITS  = MAX_FRAC_DIGITS_DEF;
    localparam int RESET_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 200;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int RANDOM_KEYS      = 1800;
    localparam int HOLD_EXPR        = 30;
    localparam int PAUSE_EXPR       = 60;

    // Keys the calculator ignores, at the two ends of the code range.
    localparam logic [7:0] KEY_NUL      = 8'h00;
    localparam logic [7:0] KEY_ALL_ONES = 8'hFF;

    typedef logic [DATA_W-1:0] fix_t;

    typedef struct packed {
        fix_t value;
        logic total;
        logic err;
    } calc_word_t;

    typedef struct {
        logic [7:0] key;
        bit         typed;
        calc_word_t want;
    } key_row_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic [7:0] s_key_code = 8'd0;
    logic       m_ready    = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic signed [DATA_W-1:0] m_display_value;
    logic       m_is_total;
    logic       m_error_flag;

    // Predicted calculator state.
    fix_t        acc_q         = '0;
    fix_t        entry_q       = '0;
    calc_op_t    op_q          = OP_NONE;
    bit          operand2_q    = 1'b0;
    bit          point_q       = 1'b0;
    int unsigned frac_digits_q = 0;
    bit          err_q         = 1'b0;
    bit          calc_err;

    calc_word_t  pending_displays[$];
    key_row_t    key_table[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int unsigned live_keys      = 0;
    bit          gaps_on        = 1'b1;
    bit          stalls_on      = 1'b1;
    bit          sink_hold_req  = 1'b0;

    keystroke_four_function_calculator_unit #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_code      (s_key_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_display_value (m_display_value),
        .m_is_total      (m_is_total),
        .m_error_flag    (m_error_flag)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Saturating two's complement add.
    function automatic fix_t sat_add(input fix_t a, input fix_t b);
        fix_t s;
        s = a + b;
        if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
            calc_err = 1'b1;
            s = a[DATA_W-1] ? NEG_MIN : POS_MAX;
        end
        return s;
    endfunction

    // Apply a sign to a wide magnitude, saturating to the signed range.
    function automatic fix_t clamp_mag(input bit neg, input logic [127:0] mag);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? {64'd0, NEG_MIN} : {64'd0, POS_MAX};
        m = mag;
        if (m > lim) begin
            calc_err = 1'b1;
            m = lim;
        end
        return neg ? fix_t'(-m) : fix_t'(m);
    endfunction

    // Evaluate the pending operation on accumulator and entry.
    function automatic fix_t calc_apply(input calc_op_t op, input fix_t a, input fix_t b);
        logic [127:0] am;
        logic [127:0] bm;
        bit           neg;
        am  = {64'd0, (a[DATA_W-1] ? -a : a)};
        bm  = {64'd0, (b[DATA_W-1] ? -b : b)};
        neg = a[DATA_W-1] ^ b[DATA_W-1];
        case (op)
            OP_ADD: return sat_add(a, b);
            OP_SUB: return sat_add(a, -b);
            OP_MUL: return clamp_mag(neg, (am * bm) >> FRAC_BITS);
            OP_DIV: begin
                if (bm == 0) begin
                    calc_err = 1'b1;
                    return a[DATA_W-1] ? NEG_MIN : POS_MAX;
                end
                return clamp_mag(neg, (am << FRAC_BITS) / bm);
            end
            default: return b;
        endcase
    endfunction

    // Advance the predicted state by one key and return the word it shows.
    function automatic calc_word_t calc_press(input logic [7:0] key);
        calc_word_t  w;
        calc_op_t    op;
        fix_t        step;
        fix_t        scale;
        int unsigned i;
        w        = '0;
        calc_err = 1'b0;
        op       = OP_NONE;
        case (key)
            KEY_ADD: op = OP_ADD;
            KEY_SUB: op = OP_SUB;
            KEY_MUL: op = OP_MUL;
            KEY_DIV: op = OP_DIV;
            default: op = OP_NONE;
        endcase
        if (key >= KEY_ZERO && key <= KEY_NINE) begin
            step = fix_t'(key - KEY_ZERO) << FRAC_BITS;
            if (!point_q) begin
                if (entry_q > (POS_MAX - step) / 10) begin
                    entry_q = POS_MAX;
                    err_q   = 1'b1;
                end else begin
                    entry_q = entry_q * 10 + step;
                end
            end else if (frac_digits_q < MAX_FRAC_DIGITS) begin
                // Fraction digit, rounded to nearest with ties up.
                frac_digits_q++;
                scale = 1;
                for (i = 0; i < frac_digits_q; i++) scale = scale * 10;
                step = (step + scale / 2) / scale;
                if (entry_q > POS_MAX - step) begin
                    entry_q = POS_MAX;
                    err_q   = 1'b1;
                end else begin
                    entry_q = entry_q + step;
                end
            end
            w.value = entry_q;
        end else if (key == KEY_POINT) begin
            point_q = 1'b1;
            w.value = entry_q;
        end else if (op != OP_NONE) begin
            // Fold the entry in left to right, then start a fresh entry.
            acc_q         = operand2_q ? calc_apply(op_q, acc_q, entry_q) : entry_q;
            err_q         = err_q | calc_err;
            op_q          = op;
            operand2_q    = 1'b1;
            entry_q       = '0;
            point_q       = 1'b0;
            frac_digits_q = 0;
            w.value       = entry_q;
        end else if (key == KEY_ENTER) begin
            w.value = operand2_q ? calc_apply(op_q, acc_q, entry_q) : entry_q;
            err_q   = err_q | calc_err;
            w.total = 1'b1;
        end else begin
            w.value = entry_q;
        end
        w.err = err_q;
        if (w.total) begin
            acc_q         = '0;
            entry_q       = '0;
            op_q          = OP_NONE;
            operand2_q    = 1'b0;
            point_q       = 1'b0;
            frac_digits_q = 0;
            err_q         = 1'b0;
        end
        return w;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic add_row(input logic [7:0] key, input bit typed = 1'b0,
                           input fix_t value = '0, input bit total = 1'b0,
                           input bit err = 1'b0);
        key_row_t row;
        row.key  = key;
        row.typed = typed;
        row.want = '{value: value, total: total, err: err};
        key_table.push_back(row);
    endtask

    // Offer one key word, wait for it to be taken, and record its expected result.
    task automatic press(input logic [7:0] key, input bit typed = 1'b0,
                         input calc_word_t want = '0);
        calc_word_t  w;
        int unsigned gap;
        s_valid    <= 1'b1;
        s_key_code <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        w = calc_press(key);
        pending_displays.push_back(typed ? want : w);
        if ((key >= KEY_ZERO && key <= KEY_NINE) || key == KEY_POINT ||
            key == KEY_ADD || key == KEY_SUB || key == KEY_MUL ||
            key == KEY_DIV || key == KEY_ENTER)
            live_keys++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Digit key, biased toward zero, with a stray key now and then.
    task automatic press_digit();
        if ($urandom_range(0, 99) < 4) press(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) press(KEY_ZERO);
        else press(KEY_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // One operand: sometimes empty, usually short, now and then long enough
    // to overflow, with an optional point and fraction digits past the limit.
    task automatic send_operand();
        int unsigned r;
        int unsigned n_int;
        int unsigned n_frac;
        int unsigned i;
        bit          with_point;
        r          = $urandom_range(0, 99);
        n_int      = (r < 8) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(8, 14);
        with_point = ($urandom_range(0, 99) < 35);
        n_frac     = with_point ? $urandom_range(0, 8) : 0;
        for (i = 0; i < n_int; i++) press_digit();
        if (with_point) begin
            press(KEY_POINT);
            if ($urandom_range(0, 9) == 0) press(KEY_POINT);
        end
        for (i = 0; i < n_frac; i++) press_digit();
    endtask

    // A chain of operands and operators, usually closed by enter.
    task automatic send_expression();
        int unsigned n_terms;
        int unsigned t;
        logic [7:0]  op_key;
        n_terms = $urandom_range(0, 4);
        send_operand();
        for (t = 0; t < n_terms; t++) begin
            case ($urandom_range(0, 3))
                0:       op_key = KEY_ADD;
                1:       op_key = KEY_SUB;
                2:       op_key = KEY_MUL;
                default: op_key = KEY_DIV;
            endcase
            press(op_key);
            send_operand();
        end
        if ($urandom_range(0, 99) < 92) press(KEY_ENTER);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned expr_count;
        // Ignored keys and enter straight after reset.
        add_row(KEY_NUL, 1'b1, '0, 1'b0, 1'b0);
        add_row(KEY_ALL_ONES, 1'b1, '0, 1'b0, 1'b0);
        add_row(KEY_ENTER, 1'b1, '0, 1'b1, 1'b0);
        // Integer and fraction digits, repeated point, first operator, add.
        add_row(KEY_ZERO + 8'd7, 1'b1, fix_t'(7) << FRAC_BITS, 1'b0, 1'b0);
        add_row(KEY_POINT);
        add_row(KEY_POINT);
        add_row(KEY_ZERO + 8'd5);
        add_row(KEY_ADD, 1'b1, '0, 1'b0, 1'b0);
        add_row(KEY_ZERO + 8'd2);
        add_row(KEY_ENTER);
        // Product far beyond the range saturates high with the error set.
        repeat (6) add_row(KEY_NINE);
        add_row(KEY_MUL);
        repeat (6) add_row(KEY_NINE);
        add_row(KEY_ENTER, 1'b1, POS_MAX, 1'b1, 1'b1);
        // Negative dividend over zero saturates low with the error set.
        add_row(KEY_SUB, 1'b1, '0, 1'b0, 1'b0);
        add_row(KEY_ZERO + 8'd5);
        add_row(KEY_DIV);
        add_row(KEY_ZERO);
        add_row(KEY_ENTER, 1'b1, NEG_MIN, 1'b1, 1'b1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (key_table[i]) press(key_table[i].key, key_table[i].typed, key_table[i].want);
        drain_results();

        // Random expressions; idling switches off for some stretches.
        live_keys  = 0;
        expr_count = 0;
        while (live_keys < RANDOM_KEYS) begin
            gaps_on   = (expr_count % 8) < 6 &&
                        !(expr_count >= HOLD_EXPR && expr_count < HOLD_EXPR + 3);
            stalls_on = (expr_count % 10) < 7;
            if (expr_count == HOLD_EXPR) sink_hold_req = 1'b1;
            if (expr_count == PAUSE_EXPR) drain_results();
            send_expression();
            expr_count++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("keystroke_four_function_calculator_unit_tb passed");
        end else begin
            $display("keystroke_four_function_calculator_unit_tb failed");
        end
        $finish;
    end

    // Result side: random stalls, runs of ready, and one long hold on request.
    initial begin : result_sink
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge aclk) begin : result_check
        calc_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_displays.size() == 0) begin
                $display("%0t: result word with none expected: value %h total %b err %b",
                         $time, m_display_value, m_is_total, m_error_flag);
                mismatch_count++;
            end else begin
                want = pending_displays.pop_front();
                if (m_display_value !== want.value) begin
                    $display("%0t: display_value expected %h got %h",
                             $time, want.value, m_display_value);
                    mismatch_count++;
                end
                if (m_is_total !== want.total) begin
                    $display("%0t: is_total expected %b got %b",
                             $time, want.total, m_is_total);
                    mismatch_count++;
                end
                if (m_error_flag !== want.err) begin
                    $display("%0t: error_flag expected %b got %b",
                             $time, want.err, m_error_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("keystroke_four_function_calculator_unit_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* keystroke_four_function_calculator_unit.f */
+incdir+sv
sv/kffc_pkg.sv
sv/kffc_mdu.sv
sv/keystroke_four_function_calculator_unit.sv
sv/kffc_sva.sv
verif/keystroke_four_function_calculator_unit_tb.sv
